/* hw/rtl/escape_time_fractal_iterator_top_assert.svh */
// Assertion macros for the escape-time iterator.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_TOP_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define ETFI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ETFI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ETFI_ASSERT_NOW(lbl, ante, cons, msg)
`define ETFI_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hw/rtl/etfi_pkg.sv */
// Shared types and constants for the escape-time iterator.
// No dependencies.
`timescale 1ns / 1ps
package etfi_pkg;

    localparam int ETFI_MAX_RESOLUTION = 1024;
    localparam int ETFI_MAX_ITERATIONS = 100;

    localparam int FX_W   = 48;
    localparam int HALF_W = FX_W / 2;
    localparam int PROD_W = 2 * FX_W;
    localparam int PIX_W  = 11;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;
    localparam int CNT_W  = 7;

    localparam logic [PROD_W-1:0] Z0_POS_LIM = (PROD_W'(1) << 39) - PROD_W'(1);
    localparam logic [PROD_W-1:0] Z0_NEG_LIM = PROD_W'(1) << 39;
    localparam logic [PROD_W-1:0] MOD_LIM    = PROD_W'(25) << 72;
    localparam logic [FX_W-1:0]   FX_POS_MAX = {1'b0, {(FX_W-1){1'b1}}};
    localparam logic [FX_W-1:0]   FX_NEG_MAX = {1'b1, {(FX_W-1){1'b0}}};

    localparam logic [IDX_W-1:0] REG_MODE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_EXP   = 3'd1;
    localparam logic [IDX_W-1:0] REG_STEP  = 3'd2;
    localparam logic [IDX_W-1:0] REG_JC_RE = 3'd3;
    localparam logic [IDX_W-1:0] REG_JC_IM = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ZX,
        S_ZY,
        S_ITER,
        S_MGO,
        S_MUL,
        S_ADD,
        S_SQGO,
        S_SQR,
        S_SQI
    } etfi_state_t;

    typedef enum logic [2:0] {
        OP_PX,
        OP_PY,
        OP_P0,
        OP_P1,
        OP_P2,
        OP_P3,
        OP_SQR,
        OP_SQI
    } etfi_op_t;

endpackage

/* hw/rtl/escape_time_fractal_iterator_top.sv */
// Escape-time iterator top level: sequencer and datapath around one shared multiplier.
// Depends on etfi_pkg, etfi_mul and the assertion header. Each 48x48 product is formed on the 24x24 unit.
// Order: the start point first, then up to MAX_ITERATIONS iterations, then the result strobe.
// Throughput: one transaction at a time; busy stays high until the result strobe.
// Reset clears the sequencer and loads the register defaults; done pulses for one cycle.
`timescale 1ns / 1ps
module escape_time_fractal_iterator_top
    import etfi_pkg::*;
#(
    parameter int MAX_RESOLUTION = ETFI_MAX_RESOLUTION,
    parameter int MAX_ITERATIONS = ETFI_MAX_ITERATIONS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [PIX_W-1:0] pixel_x,
    input  logic signed [PIX_W-1:0] pixel_y,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]        cfg_data,
    output logic                    done,
    output logic                    escaped,
    output logic [CNT_W-1:0]        iteration_count
);

`include "escape_time_fractal_iterator_top_assert.svh"

    localparam int ITER_W = (MAX_ITERATIONS > 1) ? $clog2(MAX_ITERATIONS) : 1;
    localparam logic [CFG_W-1:0] STEP_RST =
        CFG_W'((64'd1 << 28) / (MAX_RESOLUTION / 2));
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(MAX_ITERATIONS - 1);

    etfi_state_t state_reg;
    etfi_state_t state_next;

    logic              mode_reg;
    logic [3:0]        exp_reg;
    logic [CFG_W-1:0]  step_reg;
    logic [CFG_W-1:0]  jcr_reg;
    logic [CFG_W-1:0]  jci_reg;

    logic [ITER_W-1:0] iter_reg;
    logic [1:0]        j_reg;
    logic [2:0]        k_reg;
    logic              done_reg;
    logic              escaped_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              neg_reg;

    logic [PIX_W-1:0]  py_reg;
    logic [FX_W-1:0]   zr_reg;
    logic [FX_W-1:0]   zi_reg;
    logic [FX_W-1:0]   wr_reg;
    logic [FX_W-1:0]   wi_reg;
    logic [FX_W-1:0]   cr_reg;
    logic [FX_W-1:0]   ci_reg;
    logic [FX_W:0]     tr_reg;
    logic [FX_W-1:0]   ti_reg;
    logic [PROD_W-1:0] sq_reg;

    logic              mul_go;
    etfi_op_t          mul_op;
    logic              mul_done;
    logic [PROD_W-1:0] prod;
    logic [FX_W-1:0]   op_x;
    logic [FX_W-1:0]   op_y;
    logic              op_neg;
    logic [FX_W-1:0]   mag_x;
    logic [FX_W-1:0]   mag_y;

    logic [3:0]        e_eff;
    logic [FX_W-1:0]   fm_m;
    logic              fm_ovf;
    logic [FX_W-1:0]   fm_val;
    logic [FX_W-1:0]   z0_mag;
    logic [FX_W-1:0]   z0_val;
    logic              z0_ok;
    logic [FX_W:0]     ti_sum;
    logic              re_ok;
    logic              im_ok;
    logic [FX_W:0]     sr;
    logic [FX_W:0]     si;
    logic              add_ok;
    logic [PROD_W-1:0] sq_sum;
    logic              outside;
    logic              iter_last;
    logic [FX_W-1:0]   jcr_int;
    logic [FX_W-1:0]   jci_int;
    logic [31:0]       iter_ext;

    logic              fin;
    logic              fin_esc;
    logic              fin_zero;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
            exp_reg  <= 4'd2;
            step_reg <= STEP_RST;
            jcr_reg  <= '0;
            jci_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_MODE:  mode_reg <= cfg_data[0];
                REG_EXP:   exp_reg  <= cfg_data[3:0];
                REG_STEP:  step_reg <= cfg_data;
                REG_JC_RE: jcr_reg  <= cfg_data;
                REG_JC_IM: jci_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        op_x = '0;
        op_y = '0;
        unique case (mul_op)
            OP_PX:
            begin
                op_x = {{(FX_W-PIX_W){pixel_x[PIX_W-1]}}, pixel_x};
                op_y = {{(FX_W-CFG_W){1'b0}}, step_reg};
            end
            OP_PY:
            begin
                op_x = {{(FX_W-PIX_W){py_reg[PIX_W-1]}}, py_reg};
                op_y = {{(FX_W-CFG_W){1'b0}}, step_reg};
            end
            OP_P0:
            begin
                op_x = wr_reg;
                op_y = zr_reg;
            end
            OP_P1:
            begin
                op_x = wi_reg;
                op_y = zi_reg;
            end
            OP_P2:
            begin
                op_x = wr_reg;
                op_y = zi_reg;
            end
            OP_P3:
            begin
                op_x = wi_reg;
                op_y = zr_reg;
            end
            OP_SQR:
            begin
                op_x = zr_reg;
                op_y = zr_reg;
            end
            OP_SQI:
            begin
                op_x = zi_reg;
                op_y = zi_reg;
            end
            default: ;
        endcase
    end

    assign op_neg = op_x[FX_W-1] ^ op_y[FX_W-1];
    assign mag_x  = op_x[FX_W-1] ? (~op_x + FX_W'(1)) : op_x;
    assign mag_y  = op_y[FX_W-1] ? (~op_y + FX_W'(1)) : op_y;

    etfi_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (mul_go),
        .a     (mag_x),
        .b     (mag_y),
        .done  (mul_done),
        .prod  (prod)
    );

    assign e_eff = (exp_reg == 4'd0) ? 4'd1 : ((exp_reg > 4'd8) ? 4'd8 : exp_reg);

    assign fm_m   = prod[83:36];
    assign fm_ovf = (|prod[PROD_W-1:84]) || (fm_m > (neg_reg ? FX_NEG_MAX : FX_POS_MAX));
    assign fm_val = neg_reg ? (~fm_m + FX_W'(1)) : fm_m;

    assign z0_mag = {prod[39:0], 8'b0};
    assign z0_val = neg_reg ? (~z0_mag + FX_W'(1)) : z0_mag;
    assign z0_ok  = prod <= (neg_reg ? Z0_NEG_LIM : Z0_POS_LIM);

    assign ti_sum = {ti_reg[FX_W-1], ti_reg} + {fm_val[FX_W-1], fm_val};
    assign re_ok  = tr_reg[FX_W] == tr_reg[FX_W-1];
    assign im_ok  = ti_sum[FX_W] == ti_sum[FX_W-1];

    assign sr     = {wr_reg[FX_W-1], wr_reg} + {cr_reg[FX_W-1], cr_reg};
    assign si     = {wi_reg[FX_W-1], wi_reg} + {ci_reg[FX_W-1], ci_reg};
    assign add_ok = (sr[FX_W] == sr[FX_W-1]) && (si[FX_W] == si[FX_W-1]);

    assign sq_sum  = sq_reg + prod;
    assign outside = sq_sum > MOD_LIM;

    assign iter_last = iter_reg == ITER_LAST;
    assign iter_ext  = 32'(iter_reg);

    assign jcr_int = {{(FX_W-CFG_W-8){jcr_reg[CFG_W-1]}}, jcr_reg, 8'b0};
    assign jci_int = {{(FX_W-CFG_W-8){jci_reg[CFG_W-1]}}, jci_reg, 8'b0};

    always_comb
    begin
        state_next = state_reg;
        mul_go     = 1'b0;
        mul_op     = OP_PX;
        fin        = 1'b0;
        fin_esc    = 1'b0;
        fin_zero   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    mul_go     = 1'b1;
                    mul_op     = OP_PX;
                    state_next = S_ZX;
                end
            end
            S_ZX:
            begin
                if (mul_done)
                begin
                    if (!z0_ok)
                    begin
                        fin      = 1'b1;
                        fin_esc  = 1'b1;
                        fin_zero = 1'b1;
                    end
                    else
                    begin
                        mul_go     = 1'b1;
                        mul_op     = OP_PY;
                        state_next = S_ZY;
                    end
                end
            end
            S_ZY:
            begin
                if (mul_done)
                begin
                    if (!z0_ok)
                    begin
                        fin      = 1'b1;
                        fin_esc  = 1'b1;
                        fin_zero = 1'b1;
                    end
                    else
                    begin
                        state_next = S_ITER;
                    end
                end
            end
            S_ITER:
            begin
                state_next = (e_eff == 4'd1) ? S_ADD : S_MGO;
            end
            S_MGO:
            begin
                mul_go     = 1'b1;
                mul_op     = OP_P0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    if (fm_ovf)
                    begin
                        fin     = 1'b1;
                        fin_esc = 1'b1;
                    end
                    else if (j_reg != 2'd3)
                    begin
                        mul_go = 1'b1;
                        case (j_reg)
                            2'd0:    mul_op = OP_P1;
                            2'd1:    mul_op = OP_P2;
                            default: mul_op = OP_P3;
                        endcase
                    end
                    else if (!re_ok || !im_ok)
                    begin
                        fin     = 1'b1;
                        fin_esc = 1'b1;
                    end
                    else
                    begin
                        state_next = (k_reg == 3'd1) ? S_ADD : S_MGO;
                    end
                end
            end
            S_ADD:
            begin
                if (!add_ok)
                begin
                    fin     = 1'b1;
                    fin_esc = 1'b1;
                end
                else
                begin
                    state_next = S_SQGO;
                end
            end
            S_SQGO:
            begin
                mul_go     = 1'b1;
                mul_op     = OP_SQR;
                state_next = S_SQR;
            end
            S_SQR:
            begin
                if (mul_done)
                begin
                    mul_go     = 1'b1;
                    mul_op     = OP_SQI;
                    state_next = S_SQI;
                end
            end
            S_SQI:
            begin
                if (mul_done)
                begin
                    if (outside)
                    begin
                        fin     = 1'b1;
                        fin_esc = 1'b1;
                    end
                    else if (iter_last)
                    begin
                        fin = 1'b1;
                    end
                    else
                    begin
                        state_next = S_ITER;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (fin)
        begin
            state_next = S_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            iter_reg  <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= fin;
            if (state_reg == S_ZY && mul_done)
            begin
                iter_reg <= '0;
            end
            if (state_reg == S_SQI && mul_done && !outside && !iter_last)
            begin
                iter_reg <= iter_reg + ITER_W'(1);
            end
            if (state_reg == S_ITER)
            begin
                k_reg <= 3'(e_eff - 4'd1);
            end
            if (state_reg == S_MGO)
            begin
                j_reg <= '0;
            end
            if (state_reg == S_MUL && mul_done && !fm_ovf)
            begin
                if (j_reg != 2'd3)
                begin
                    j_reg <= j_reg + 2'd1;
                end
                else
                begin
                    k_reg <= k_reg - 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mul_go)
        begin
            neg_reg <= op_neg;
        end
        if (fin)
        begin
            escaped_reg <= fin_esc;
            count_reg   <= (fin_esc && !fin_zero) ? iter_ext[CNT_W-1:0] : '0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    py_reg <= pixel_y;
                end
            end
            S_ZX:
            begin
                if (mul_done)
                begin
                    zr_reg <= z0_val;
                end
            end
            S_ZY:
            begin
                if (mul_done)
                begin
                    zi_reg <= z0_val;
                    cr_reg <= mode_reg ? jcr_int : zr_reg;
                    ci_reg <= mode_reg ? jci_int : z0_val;
                end
            end
            S_ITER:
            begin
                wr_reg <= zr_reg;
                wi_reg <= zi_reg;
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    case (j_reg)
                        2'd0: tr_reg <= {fm_val[FX_W-1], fm_val};
                        2'd1: tr_reg <= tr_reg - {fm_val[FX_W-1], fm_val};
                        2'd2: ti_reg <= fm_val;
                        default:
                        begin
                            wr_reg <= tr_reg[FX_W-1:0];
                            wi_reg <= ti_sum[FX_W-1:0];
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                zr_reg <= sr[FX_W-1:0];
                zi_reg <= si[FX_W-1:0];
            end
            S_SQR:
            begin
                if (mul_done)
                begin
                    sq_reg <= prod;
                end
            end
            default: ;
        endcase
    end

    assign busy            = state_reg != S_IDLE;
    assign done            = done_reg;
    assign escaped         = escaped_reg;
    assign iteration_count = count_reg;

    `ETFI_ASSERT_NEXT(a_start_busy, start && !busy, busy,
        "accepted transaction did not raise busy")
    `ETFI_ASSERT_NOW(a_done_after_work, done, $past(state_reg != S_IDLE),
        "result strobe without work in progress")
    `ETFI_ASSERT_NOW(a_mul_done_waiting, mul_done,
        state_reg == S_ZX || state_reg == S_ZY || state_reg == S_MUL ||
        state_reg == S_SQR || state_reg == S_SQI,
        "product finished while sequencer was not waiting")
    `ETFI_ASSERT_NOW(a_inside_count_zero, done && !escaped, iteration_count == '0,
        "nonzero count on a point that did not escape")

endmodule

/* hw/rtl/etfi_mul.sv */
// 48x48 unsigned multiplier built from one 24x24 multiplier over four passes.
// Depends on etfi_pkg; result valid in the cycle done is high.
`timescale 1ns / 1ps
module etfi_mul
    import etfi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [FX_W-1:0]   a,
    input  logic [FX_W-1:0]   b,
    output logic              done,
    output logic [PROD_W-1:0] prod
);

    logic [FX_W-1:0]   a_reg;
    logic [FX_W-1:0]   b_reg;
    logic [1:0]        cnt_reg;
    logic [1:0]        sel_reg;
    logic              run_reg;
    logic              pv_reg;
    logic              last_reg;
    logic              done_reg;
    logic [FX_W-1:0]   pp_reg;
    logic [PROD_W-1:0] acc_reg;

    logic [HALF_W-1:0] a_part;
    logic [HALF_W-1:0] b_part;
    logic [FX_W-1:0]   pp_next;
    logic [PROD_W-1:0] sh_one;
    logic [PROD_W-1:0] sh_pp;

    assign a_part  = cnt_reg[1] ? a_reg[FX_W-1:HALF_W] : a_reg[HALF_W-1:0];
    assign b_part  = cnt_reg[0] ? b_reg[FX_W-1:HALF_W] : b_reg[HALF_W-1:0];
    assign pp_next = a_part * b_part;
    assign sh_one  = sel_reg[1] ? (PROD_W'(pp_reg) << HALF_W) : PROD_W'(pp_reg);
    assign sh_pp   = sel_reg[0] ? (sh_one << HALF_W) : sh_one;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            pv_reg   <= 1'b0;
            last_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (go)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b1;
            pv_reg   <= 1'b0;
            last_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            pv_reg   <= run_reg;
            last_reg <= run_reg && (cnt_reg == 2'd3);
            done_reg <= pv_reg && last_reg;
            if (run_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else
        begin
            if (run_reg)
            begin
                pp_reg  <= pp_next;
                sel_reg <= cnt_reg;
            end
            if (pv_reg)
            begin
                acc_reg <= acc_reg + sh_pp;
            end
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule
